>>> src/esp_ctl_pkg.sv
// Package: register indexes, reset values and widths for the wheel speed regulator.
package esp_ctl_pkg;

    localparam int NUM_REGS = 8;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 20;

    localparam logic [CFG_IDX_W-1:0] REG_TARGET_ONE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_TWO = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PERIOD     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DISTANCE   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_HOLES      = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_SPEED  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_PWM_MOD    = 3'd7;

    localparam logic [9:0]  RST_TARGET    = 10'd10;
    localparam logic [7:0]  RST_GAIN      = 8'd15;
    localparam logic [15:0] RST_PERIOD    = 16'd60000;
    localparam logic [19:0] RST_DISTANCE  = 20'd20106;
    localparam logic [6:0]  RST_HOLES     = 7'd8;
    localparam logic [15:0] RST_MAX_SPEED = 16'd500;
    localparam logic [15:0] RST_PWM_MOD   = 16'd1000;

    localparam logic [15:0] SPEED_SAT = 16'hFFFF;

    localparam int DEF_MOTOR_CHANNELS = 2;
    localparam int DEF_TIMER_BITS = 16;
    localparam int DEF_OVERFLOW_BITS = 8;

endpackage

>>> src/encoder_speed_p_controller.sv
// Top level: two-channel encoder period speed measurement with proportional duty control.
//  channel  | signals                                             | direction
//  s_       | s_valid s_ready s_command s_motor s_encoder_level   | request in
//           | s_timer_count                                       |
//  m_       | m_valid m_ready m_motor_out m_measured_speed m_duty | request out
//           | m_divide_fault                                      |
//  cfg_     | cfg_valid cfg_ready cfg_index cfg_data              | register write
// Ticks and non-rising samples are handled in S_IDLE. A rising edge runs through one shared
// restoring divider, one quotient bit per cycle, two to four times.
// s_ready is high only while idle.
// Reset (aresetn low, synchronous) loads register defaults and clears all channel state.
// A result waits in the output register while m_ready is low; a later result stalls in S_OUT until it is taken.
module encoder_speed_p_controller #(
    parameter int MOTOR_CHANNELS = esp_ctl_pkg::DEF_MOTOR_CHANNELS,
    parameter int TIMER_BITS     = esp_ctl_pkg::DEF_TIMER_BITS,
    parameter int OVERFLOW_BITS  = esp_ctl_pkg::DEF_OVERFLOW_BITS
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic                                s_command,
    input  logic                                s_motor,
    input  logic                                s_encoder_level,
    input  logic [15:0]                         s_timer_count,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic                                m_motor_out,
    output logic [15:0]                         m_measured_speed,
    output logic [15:0]                         m_duty,
    output logic                                m_divide_fault,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [esp_ctl_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [esp_ctl_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import esp_ctl_pkg::*;

    localparam int IDX_W  = (MOTOR_CHANNELS > 1) ? $clog2(MOTOR_CHANNELS) : 1;
    localparam int PO_W   = 16 + OVERFLOW_BITS;
    localparam int TK_W   = ((PO_W > TIMER_BITS) ? PO_W : TIMER_BITS) + 2;
    localparam int DIV_W  = (TK_W + 4 > 32) ? TK_W + 4 : 32;
    localparam int TURN_W = DIV_W + 7;
    localparam int RW     = DIV_W + 8;
    localparam int CNT_W  = $clog2(DIV_W + 1);
    localparam int CMD_W  = 27;
    localparam int C100_W = 34;
    localparam logic [OVERFLOW_BITS-1:0] OVF_MAX = {OVERFLOW_BITS{1'b1}};

    typedef enum logic [10:0] {
        S_IDLE  = 11'b00000000001,
        S_PROD  = 11'b00000000010,
        S_ELAP  = 11'b00000000100,
        S_DIV   = 11'b00000001000,
        S_TURN  = 11'b00000010000,
        S_SPD   = 11'b00000100000,
        S_ERR   = 11'b00001000000,
        S_LIM   = 11'b00010000000,
        S_CLAMP = 11'b00100000000,
        S_DMUL  = 11'b01000000000,
        S_OUT   = 11'b10000000000
    } state_t;

    typedef enum logic [1:0] {
        RET_MS    = 2'd0,
        RET_SPEED = 2'd1,
        RET_LIM   = 2'd2,
        RET_DUTY  = 2'd3
    } div_ret_t;

    state_t   state_reg;
    div_ret_t ret_reg;

    logic [9:0]  tgt1_reg, tgt2_reg;
    logic [7:0]  gain_reg;
    logic [15:0] period_reg, maxs_reg, pwm_reg;
    logic [19:0] dist_reg;
    logic [6:0]  holes_reg;

    logic                     prev_reg [MOTOR_CHANNELS];
    logic [TIMER_BITS-1:0]    last_reg [MOTOR_CHANNELS];
    logic [OVERFLOW_BITS-1:0] ovf_reg  [MOTOR_CHANNELS];

    logic [IDX_W-1:0]         idx_reg;
    logic                     motor_reg;
    logic [TIMER_BITS-1:0]    tc_reg;
    logic [PO_W-1:0]          po_reg;
    logic [TURN_W-1:0]        turn_reg;
    logic [15:0]              speed_reg;
    logic                     fault_reg;
    logic signed [CMD_W-1:0]  cmd_reg;
    logic signed [C100_W-1:0] c100_reg;
    logic [22:0]              hi_reg, lo_reg;
    logic [15:0]              cmdc_reg;
    logic [31:0]              prod_reg;
    logic [15:0]              duty_reg;

    logic [DIV_W-1:0] q_reg;
    logic [RW-1:0]    rem_reg, dvs_reg;
    logic [CNT_W-1:0] cnt_reg;

    logic                m_valid_reg, m_motor_reg, m_fault_reg;
    logic [15:0]         m_speed_reg, m_duty_reg;

    logic [15:0]           period, maxs;
    logic [IDX_W-1:0]      s_idx;
    logic                  s_in_range;
    logic [TIMER_BITS-1:0] s_tc;
    logic signed [TK_W-1:0] ticks;
    logic [TK_W-1:0]       ticks_pos;
    logic [DIV_W-1:0]      ms_dividend;
    logic [RW-1:0]         r2;
    logic                  r_ge;
    logic signed [17:0]    diff;
    logic [9:0]            target;
    logic                  out_free;

    assign period     = (period_reg == 16'd0) ? 16'd1 : period_reg;
    assign maxs       = (maxs_reg == 16'd0) ? 16'd1 : maxs_reg;
    assign s_idx      = IDX_W'(s_motor);
    assign s_in_range = (32'(s_motor) < MOTOR_CHANNELS);
    assign s_tc       = TIMER_BITS'(s_timer_count);
    assign out_free   = !m_valid_reg || m_ready;

    always_comb begin
        ticks = $signed(TK_W'(tc_reg)) + $signed(TK_W'(po_reg)) - $signed(TK_W'(last_reg[idx_reg]));
        ticks_pos = (ticks < 0) ? '0 : TK_W'(ticks);
        ms_dividend = (DIV_W'(ticks_pos) << 3) + (DIV_W'(ticks_pos) << 1);
        r2 = {rem_reg[RW-2:0], q_reg[DIV_W-1]};
        r_ge = (r2 >= dvs_reg);
        target = motor_reg ? tgt2_reg : tgt1_reg;
        diff = $signed({8'b0, target}) - $signed({2'b0, speed_reg});
    end

    assign s_ready   = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;

    // configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tgt1_reg   <= RST_TARGET;
            tgt2_reg   <= RST_TARGET;
            gain_reg   <= RST_GAIN;
            period_reg <= RST_PERIOD;
            dist_reg   <= RST_DISTANCE;
            holes_reg  <= RST_HOLES;
            maxs_reg   <= RST_MAX_SPEED;
            pwm_reg    <= RST_PWM_MOD;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_TARGET_ONE: tgt1_reg   <= cfg_data[9:0];
                REG_TARGET_TWO: tgt2_reg   <= cfg_data[9:0];
                REG_GAIN:       gain_reg   <= cfg_data[7:0];
                REG_PERIOD:     period_reg <= cfg_data[15:0];
                REG_DISTANCE:   dist_reg   <= cfg_data;
                REG_HOLES:      holes_reg  <= cfg_data[6:0];
                REG_MAX_SPEED:  maxs_reg   <= cfg_data[15:0];
                REG_PWM_MOD:    pwm_reg    <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // sequencer, channel state and shared divider
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            ret_reg     <= RET_MS;
            m_valid_reg <= 1'b0;
            cnt_reg     <= '0;
            for (int i = 0; i < MOTOR_CHANNELS; i++) begin
                prev_reg[i] <= 1'b0;
                last_reg[i] <= '0;
                ovf_reg[i]  <= '0;
            end
        end else begin
            if (m_valid_reg && m_ready && (state_reg != S_OUT)) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (s_valid) begin
                        if (!s_command) begin
                            for (int i = 0; i < MOTOR_CHANNELS; i++) begin
                                if (ovf_reg[i] != OVF_MAX) begin
                                    ovf_reg[i] <= ovf_reg[i] + 1'b1;
                                end
                            end
                        end else if (s_in_range) begin
                            prev_reg[s_idx] <= s_encoder_level;
                            if (!prev_reg[s_idx] && s_encoder_level) begin
                                idx_reg   <= s_idx;
                                motor_reg <= s_motor;
                                tc_reg    <= s_tc;
                                state_reg <= S_PROD;
                            end
                        end
                    end
                end
                S_PROD: begin
                    po_reg    <= PO_W'(period) * PO_W'(ovf_reg[idx_reg]);
                    state_reg <= S_ELAP;
                end
                S_ELAP: begin
                    last_reg[idx_reg] <= tc_reg;
                    ovf_reg[idx_reg]  <= '0;
                    q_reg     <= ms_dividend;
                    rem_reg   <= '0;
                    dvs_reg   <= RW'(period);
                    cnt_reg   <= CNT_W'(DIV_W);
                    ret_reg   <= RET_MS;
                    state_reg <= S_DIV;
                end
                S_DIV: begin
                    if (cnt_reg != '0) begin
                        rem_reg <= r_ge ? (r2 - dvs_reg) : r2;
                        q_reg   <= {q_reg[DIV_W-2:0], r_ge};
                        cnt_reg <= cnt_reg - 1'b1;
                    end else begin
                        case (ret_reg)
                            RET_MS: state_reg <= S_TURN;
                            RET_SPEED: begin
                                speed_reg <= (q_reg > DIV_W'(SPEED_SAT)) ? SPEED_SAT : q_reg[15:0];
                                fault_reg <= 1'b0;
                                state_reg <= S_ERR;
                            end
                            RET_LIM: begin
                                cmdc_reg  <= q_reg[15:0];
                                state_reg <= S_DMUL;
                            end
                            default: begin
                                duty_reg  <= q_reg[15:0];
                                state_reg <= S_OUT;
                            end
                        endcase
                    end
                end
                S_TURN: begin
                    turn_reg  <= TURN_W'(holes_reg) * TURN_W'(q_reg);
                    state_reg <= S_SPD;
                end
                S_SPD: begin
                    if (turn_reg == '0) begin
                        speed_reg <= SPEED_SAT;
                        fault_reg <= 1'b1;
                        state_reg <= S_ERR;
                    end else begin
                        q_reg     <= DIV_W'(dist_reg);
                        rem_reg   <= '0;
                        dvs_reg   <= RW'(turn_reg);
                        cnt_reg   <= CNT_W'(DIV_W);
                        ret_reg   <= RET_SPEED;
                        state_reg <= S_DIV;
                    end
                end
                S_ERR: begin
                    cmd_reg   <= CMD_W'($signed({1'b0, gain_reg})) * CMD_W'(diff);
                    state_reg <= S_LIM;
                end
                S_LIM: begin
                    c100_reg  <= C100_W'(cmd_reg) * 34'sd100;
                    hi_reg    <= 23'(maxs) * 23'd95;
                    lo_reg    <= 23'(maxs) * 23'd5;
                    state_reg <= S_CLAMP;
                end
                S_CLAMP: begin
                    if (c100_reg > $signed({11'b0, hi_reg})) begin
                        q_reg     <= DIV_W'(hi_reg);
                        rem_reg   <= '0;
                        dvs_reg   <= RW'(100);
                        cnt_reg   <= CNT_W'(DIV_W);
                        ret_reg   <= RET_LIM;
                        state_reg <= S_DIV;
                    end else if (c100_reg < $signed({11'b0, lo_reg})) begin
                        q_reg     <= DIV_W'(lo_reg);
                        rem_reg   <= '0;
                        dvs_reg   <= RW'(100);
                        cnt_reg   <= CNT_W'(DIV_W);
                        ret_reg   <= RET_LIM;
                        state_reg <= S_DIV;
                    end else begin
                        cmdc_reg  <= cmd_reg[15:0];
                        state_reg <= S_DMUL;
                    end
                end
                S_DMUL: begin
                    prod_reg <= 32'(cmdc_reg) * 32'(pwm_reg);
                    // second pass starts the duty divide
                    if (ret_reg == RET_DUTY) begin
                        q_reg     <= DIV_W'(prod_reg);
                        rem_reg   <= '0;
                        dvs_reg   <= RW'(maxs);
                        cnt_reg   <= CNT_W'(DIV_W);
                        state_reg <= S_DIV;
                    end else begin
                        ret_reg <= RET_DUTY;
                    end
                end
                S_OUT: begin
                    if (out_free) begin
                        m_valid_reg <= 1'b1;
                        m_motor_reg <= motor_reg;
                        m_speed_reg <= speed_reg;
                        m_duty_reg  <= duty_reg;
                        m_fault_reg <= fault_reg;
                        state_reg   <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_motor_out      = m_motor_reg;
    assign m_measured_speed = m_speed_reg;
    assign m_duty           = m_duty_reg;
    assign m_divide_fault   = m_fault_reg;

    a_state_onehot: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot(state_reg))
        else $error("sequencer state not one-hot");

    a_out_load: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_OUT && out_free) |=> (m_valid && state_reg == S_IDLE))
        else $error("result not loaded");

    a_fault_sat: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_divide_fault) |-> (m_measured_speed == SPEED_SAT))
        else $error("divide fault without saturated speed");

    a_busy_no_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DIV) |-> !s_ready)
        else $error("request accepted while dividing");

endmodule

>>> tb/sv/tb_encoder_speed_p_controller.sv
// Testbench: directed and random stimulus with a self-checking speed and duty predictor.
`timescale 1ns / 100ps

module tb_encoder_speed_p_controller;
    import esp_ctl_pkg::*;

    localparam int DRAIN_CYCLES = 200;
    localparam int STALL_LIMIT  = 20000;
    localparam bit CMD_TICK     = 1'b0;
    localparam bit CMD_SAMPLE   = 1'b1;

    typedef struct {
        bit          mot;
        logic [15:0] spd;
        logic [15:0] duty;
        bit          fault;
    } speed_res_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0, s_ready;
    logic s_command = 1'b0, s_motor = 1'b0, s_encoder_level = 1'b0;
    logic [15:0] s_timer_count = '0;
    logic m_valid, m_ready = 1'b0;
    logic m_motor_out, m_divide_fault;
    logic [15:0] m_measured_speed, m_duty;
    logic cfg_valid = 1'b0, cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // predictor copy of registers and channel state
    logic [9:0]  tgt_one, tgt_two;
    logic [7:0]  kp;
    logic [15:0] period_ticks, max_spd, pwm_mod;
    logic [19:0] dist_num;
    logic [6:0]  holes;
    bit          prev_lvl [2];
    logic [15:0] last_tmr [2];
    logic [7:0]  ovf_cnt [2];

    speed_res_t expected_speeds [$];
    int err_cnt = 0;
    int snd_idle_pct = 17, rcv_idle_pct = 78;
    int stall_cnt = 0;
    bit chan_lvl [2];

    encoder_speed_p_controller u_top (.*);

    always #1 aclk = ~aclk;

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= rcv_idle_pct);
    end

    function automatic bit predict_speed(input bit cmd, input bit mot, input bit lvl,
                                         input logic [15:0] tc, output speed_res_t r);
        longint ticks, ms, turn, spd, c, tgt, hi, lo, per, mx;
        bit p;
        r = '{default: 0};
        if (cmd == CMD_TICK) begin
            for (int i = 0; i < 2; i++)
                if (ovf_cnt[i] != 8'hFF) ovf_cnt[i]++;
            return 1'b0;
        end
        p = prev_lvl[mot];
        prev_lvl[mot] = lvl;
        if (!(!p && lvl)) return 1'b0;
        per = (period_ticks == 0) ? 1 : longint'(period_ticks);
        mx  = (max_spd == 0) ? 1 : longint'(max_spd);
        ticks = longint'(tc) + per * longint'(ovf_cnt[mot]) - longint'(last_tmr[mot]);
        if (ticks < 0) ticks = 0;
        ms = ticks * 10 / per;
        turn = longint'(holes) * ms;
        if (turn == 0) begin
            spd = 65535;
            r.fault = 1'b1;
        end else begin
            spd = longint'(dist_num) / turn;
            if (spd > 65535) spd = 65535;
        end
        last_tmr[mot] = tc;
        ovf_cnt[mot] = '0;
        tgt = mot ? longint'(tgt_two) : longint'(tgt_one);
        c = longint'(kp) * (tgt - spd);
        hi = mx * 95;
        lo = mx * 5;
        if (c * 100 > hi) c = hi / 100;
        else if (c * 100 < lo) c = lo / 100;
        r.mot  = mot;
        r.spd  = spd[15:0];
        r.duty = 16'(c * longint'(pwm_mod) / mx);
        return 1'b1;
    endfunction

    task automatic send_item(input bit cmd, input bit mot, input bit lvl,
                             input logic [15:0] tc);
        speed_res_t r;
        int gap;
        if ($urandom_range(0, 99) < snd_idle_pct) begin
            gap = $urandom_range(1, 6);
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_command <= cmd;
        s_motor <= mot;
        s_encoder_level <= lvl;
        s_timer_count <= tc;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        if (predict_speed(cmd, mot, lvl, tc, r)) expected_speeds.push_back(r);
    endtask

    task automatic wait_idle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (expected_speeds.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input longint val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= CFG_DATA_W'(val);
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        case (idx)
            REG_TARGET_ONE: tgt_one = 10'(val);
            REG_TARGET_TWO: tgt_two = 10'(val);
            REG_GAIN:       kp = 8'(val);
            REG_PERIOD:     period_ticks = 16'(val);
            REG_DISTANCE:   dist_num = 20'(val);
            REG_HOLES:      holes = 7'(val);
            REG_MAX_SPEED:  max_spd = 16'(val);
            default:        pwm_mod = 16'(val);
        endcase
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic write_all(input longint t1, t2, g, per, d, h, mx, pm);
        wait_idle();
        write_reg(REG_TARGET_ONE, t1);
        write_reg(REG_TARGET_TWO, t2);
        write_reg(REG_GAIN, g);
        write_reg(REG_PERIOD, per);
        write_reg(REG_DISTANCE, d);
        write_reg(REG_HOLES, h);
        write_reg(REG_MAX_SPEED, mx);
        write_reg(REG_PWM_MOD, pm);
    endtask

    task automatic send_random(input int n);
        bit mot, lvl;
        int pick;
        for (int i = 0; i < n; i++) begin
            pick = $urandom_range(0, 99);
            mot = 1'($urandom_range(0, 1));
            if (pick < 25) begin
                send_item(CMD_TICK, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                          16'($urandom));
            end else begin
                lvl = (pick < 85) ? !chan_lvl[mot] : bit'($urandom_range(0, 1));
                chan_lvl[mot] = lvl;
                send_item(CMD_SAMPLE, mot, lvl, 16'($urandom));
            end
        end
    endtask

    task automatic test_directed();
        send_item(CMD_SAMPLE, 1'b0, 1'b1, 16'h0000);
        send_item(CMD_SAMPLE, 1'b0, 1'b1, 16'h1234);
        send_item(CMD_SAMPLE, 1'b0, 1'b0, 16'hFFFF);
        send_item(CMD_TICK, 1'b1, 1'b1, 16'hFFFF);
        send_item(CMD_TICK, 1'b0, 1'b0, 16'h0000);
        send_item(CMD_SAMPLE, 1'b0, 1'b1, 16'hFFFF);
        send_item(CMD_SAMPLE, 1'b1, 1'b1, 16'd30000);
        send_item(CMD_SAMPLE, 1'b1, 1'b0, 16'd0);
        send_item(CMD_TICK, 1'b0, 1'b0, 16'd0);
        send_item(CMD_SAMPLE, 1'b1, 1'b1, 16'd100);
        // negative elapsed time
        send_item(CMD_SAMPLE, 1'b1, 1'b0, 16'd0);
        send_item(CMD_SAMPLE, 1'b1, 1'b1, 16'd50);
        send_item(CMD_SAMPLE, 1'b0, 1'b0, 16'd0);
        send_item(CMD_SAMPLE, 1'b0, 1'b1, 16'd0);
        chan_lvl[0] = 1'b1;
        chan_lvl[1] = 1'b1;
    endtask

    task automatic test_overflow_saturation();
        send_item(CMD_SAMPLE, 1'b0, 1'b0, 16'd0);
        repeat (300) send_item(CMD_TICK, 1'b0, 1'b0, 16'($urandom));
        send_item(CMD_SAMPLE, 1'b0, 1'b1, 16'hFFFF);
        send_item(CMD_SAMPLE, 1'b1, 1'b0, 16'd0);
        send_item(CMD_SAMPLE, 1'b1, 1'b1, 16'd0);
    endtask

    task automatic test_register_extremes();
        write_all(0, 0, 0, 0, 0, 1, 0, 1);
        send_random(25);
        write_all(1023, 1023, 255, 65535, 1048575, 64, 65535, 65535);
        send_random(25);
        write_all(1023, 0, 255, 1, 1048575, 1, 1, 65535);
        send_random(25);
        write_all(300, 700, 3, 600, 20106, 127, 1000, 4000);
        send_random(25);
        write_all(10, 10, 15, 60000, 20106, 8, 500, 1000);
        send_random(25);
    endtask

    task automatic test_random_traffic();
        write_all(200, 50, 7, 6000, 31416, 20, 400, 2500);
        snd_idle_pct = 17;
        rcv_idle_pct = 78;
        send_random(100);
        wait_idle();
        send_random(50);
        snd_idle_pct = 78;
        rcv_idle_pct = 17;
        send_random(150);
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
        send_random(150);
    endtask

    always @(posedge aclk) begin
        speed_res_t e;
        if (aresetn && m_valid && m_ready) begin
            if (expected_speeds.size() == 0) begin
                $error("result with none expected");
                err_cnt++;
            end else begin
                e = expected_speeds.pop_front();
                if (m_motor_out !== e.mot) begin
                    $error("motor_out exp %0d got %0d", e.mot, m_motor_out);
                    err_cnt++;
                end
                if (m_measured_speed !== e.spd) begin
                    $error("measured_speed exp %0d got %0d", e.spd, m_measured_speed);
                    err_cnt++;
                end
                if (m_duty !== e.duty) begin
                    $error("duty exp %0d got %0d", e.duty, m_duty);
                    err_cnt++;
                end
                if (m_divide_fault !== e.fault) begin
                    $error("divide_fault exp %0d got %0d", e.fault, m_divide_fault);
                    err_cnt++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            stall_cnt <= 0;
        else
            stall_cnt <= stall_cnt + 1;
        if (stall_cnt >= STALL_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin
        tgt_one = RST_TARGET;
        tgt_two = RST_TARGET;
        kp = RST_GAIN;
        period_ticks = RST_PERIOD;
        dist_num = RST_DISTANCE;
        holes = RST_HOLES;
        max_spd = RST_MAX_SPEED;
        pwm_mod = RST_PWM_MOD;
        for (int i = 0; i < 2; i++) begin
            prev_lvl[i] = 1'b0;
            last_tmr[i] = '0;
            ovf_cnt[i] = '0;
            chan_lvl[i] = 1'b0;
        end
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_overflow_saturation();
        test_register_extremes();
        test_random_traffic();
        wait_idle();
        if (err_cnt == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
